### hdl/csr_spmv_pkg.sv
// ----------------------------------------------------------------------------
// csr_spmv_pkg
// Shared types and constants of the CSR sparse matrix times vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_spmv_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int POS_W      = 10;
  localparam int ADDR_W     = $clog2(MAX_SIZE);
  localparam int SIZE_W     = 11;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 48;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // input command codes
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENTRY   = 2'd1,
    CMD_ROW_END = 2'd2
  } cmd_t;

  // work kinds handed from the front to the back
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_MAC     = 2'd1,
    OP_SKIP    = 2'd2,
    OP_ROW_END = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } q_entry_t;

endpackage

`default_nettype wire

### hdl/csr_spmv_front.sv
// ----------------------------------------------------------------------------
// csr_spmv_front
// Holds the size register, accepts commands and classifies them into work
// for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     cmd,
  input  logic [csr_spmv_pkg::POS_W-1:0] position,
  input  logic signed [31:0]             operand_value,
  input  logic                           matrix_size_we,
  input  logic [csr_spmv_pkg::SIZE_W-1:0] matrix_size,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           push,
  output csr_spmv_pkg::q_entry_t         push_entry,
  output logic [csr_spmv_pkg::ADDR_W-1:0] size_m1
);
  import csr_spmv_pkg::*;

  logic [SIZE_W-1:0] size_reg;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(MAX_SIZE);
    end else if (matrix_size_we) begin
      size_reg <= matrix_size;
    end
  end

  // zero counts as one, anything past the store depth as the full depth
  always_comb begin
    if (size_reg == '0) begin
      size_m1 = '0;
    end else if (size_reg >= SIZE_W'(MAX_SIZE)) begin
      size_m1 = ADDR_W'(MAX_SIZE - 1);
    end else begin
      size_m1 = ADDR_W'(size_reg - SIZE_W'(1));
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  always_comb begin
    push             = 1'b0;
    push_entry.op    = OP_LOAD;
    push_entry.pos   = position;
    push_entry.value = operand_value;
    if (accept) begin
      unique case (cmd)
        CMD_LOAD: begin
          push          = 1'b1;
          push_entry.op = OP_LOAD;
        end
        CMD_ENTRY: begin
          push          = 1'b1;
          push_entry.op = (ADDR_W'(position) > size_m1) ? OP_SKIP : OP_MAC;
        end
        CMD_ROW_END: begin
          push          = 1'b1;
          push_entry.op = OP_ROW_END;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/csr_spmv_queue.sv
// ----------------------------------------------------------------------------
// csr_spmv_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  csr_spmv_pkg::q_entry_t push_entry,
  input  logic                   pop,
  output logic                   full,
  output logic                   not_empty,
  output csr_spmv_pkg::q_entry_t head
);
  import csr_spmv_pkg::*;

  q_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/csr_spmv_back.sv
// ----------------------------------------------------------------------------
// csr_spmv_back
// Vector store, multiply pipeline, saturating row accumulator and the
// registered row result.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_spmv_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  csr_spmv_pkg::q_entry_t          head,
  input  logic [csr_spmv_pkg::ADDR_W-1:0] size_m1,
  output logic                            pop,
  output logic                            done,
  output logic [csr_spmv_pkg::POS_W-1:0]  row_index,
  output logic signed [47:0]              row_sum,
  output logic                            last_row,
  output logic                            bad_column
);
  import csr_spmv_pkg::*;

  logic signed [VAL_W-1:0]  vec_mem [MAX_SIZE];
  logic signed [VAL_W-1:0]  rd_data;
  logic signed [VAL_W-1:0]  op1;
  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  logic                     v2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  prod_q;
  logic                     err_flag;
  logic [POS_W-1:0]         row_counter;
  logic                     is_last;
  logic                     pop_load;
  logic                     pop_mac;
  logic                     pop_skip;
  logic                     pop_end;

  // a row end waits until every product of its row has landed
  assign pop      = q_valid && ((head.op != OP_ROW_END) || (!v1 && !v2));
  assign pop_load = pop && (head.op == OP_LOAD);
  assign pop_mac  = pop && (head.op == OP_MAC);
  assign pop_skip = pop && (head.op == OP_SKIP);
  assign pop_end  = pop && (head.op == OP_ROW_END);

  always_ff @(posedge clk) begin
    if (pop_load) begin
      vec_mem[ADDR_W'(head.pos)] <= $signed(head.value);
    end
  end

  always_ff @(posedge clk) begin
    if (pop_mac) begin
      rd_data <= vec_mem[ADDR_W'(head.pos)];
    end
  end

  always_ff @(posedge clk) begin
    op1  <= $signed(head.value);
    prod <= PROD_W'(rd_data) * PROD_W'(op1);
  end

  // arithmetic shift gives the floor of the q32.32 product
  assign prod_q   = ACC_W'(prod >>> FRAC_W);
  assign sum_wide = {acc[ACC_W-1], acc} + {prod_q[ACC_W-1], prod_q};

  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      acc_next = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum_wide[ACC_W-1:0];
    end
  end

  assign is_last = (ADDR_W'(row_counter) >= size_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      acc         <= '0;
      err_flag    <= 1'b0;
      row_counter <= '0;
      done        <= 1'b0;
    end else begin
      v1   <= pop_mac;
      v2   <= v1;
      done <= pop_end;
      if (pop_end) begin
        acc         <= '0;
        err_flag    <= 1'b0;
        row_counter <= is_last ? '0 : row_counter + POS_W'(1);
      end else begin
        if (v2) begin
          acc <= acc_next;
        end
        if (pop_skip) begin
          err_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_end) begin
      row_index  <= row_counter;
      row_sum    <= acc;
      last_row   <= is_last;
      bad_column <= err_flag;
    end
  end

endmodule

`default_nettype wire

### hdl/csr_sparse_matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_unit
// CSR sparse matrix times dense vector: vector loads, nonzero entries and
// row ends stream in; each row end gives the row's saturated Q32.16 sum.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-------------------
//  command  | cmd, position, operand_value                   | start & !busy
//  result   | row_index, row_sum, last_row, bad_column       | done, one cycle
//  config   | matrix_size                                    | matrix_size_we
//
// One beat a cycle is taken while the four-entry queue has room; loads and
// entries leave it at one a cycle. A row end leaves the queue only once the
// read-multiply-accumulate pipeline (memory read, multiply, add) is empty, and
// its result is registered and shows in the cycle after.
// Synchronous reset clears control state; the vector store is not cleared.
// The result side cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd,
  input  logic [csr_spmv_pkg::POS_W-1:0]   position,
  input  logic signed [31:0]               operand_value,
  input  logic                             matrix_size_we,
  input  logic [csr_spmv_pkg::SIZE_W-1:0]  matrix_size,
  output logic                             done,
  output logic [csr_spmv_pkg::POS_W-1:0]   row_index,
  output logic signed [47:0]               row_sum,
  output logic                             last_row,
  output logic                             bad_column
);
  import csr_spmv_pkg::*;

  logic              q_push;
  q_entry_t          q_push_entry;
  logic              q_pop;
  logic              q_full;
  logic              q_valid;
  q_entry_t          q_head;
  logic [ADDR_W-1:0] size_m1;

  csr_spmv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .position       (position),
    .operand_value  (operand_value),
    .matrix_size_we (matrix_size_we),
    .matrix_size    (matrix_size),
    .q_full         (q_full),
    .busy           (busy),
    .push           (q_push),
    .push_entry     (q_push_entry),
    .size_m1        (size_m1)
  );

  csr_spmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  csr_spmv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (q_head),
    .size_m1    (size_m1),
    .pop        (q_pop),
    .done       (done),
    .row_index  (row_index),
    .row_sum    (row_sum),
    .last_row   (last_row),
    .bad_column (bad_column)
  );

  // no beat is pushed into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("push into full queue");

  // the back end never pops an empty queue
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // every result follows a row end leaving the queue
  a_done_after_row_end: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(q_pop) && ($past(q_head.op) == OP_ROW_END)))
    else $error("result without row end");

endmodule

`default_nettype wire
